>>> design/bouncing_disc_table_update_unit_assert.svh
// ----------------------------------------------------------------------------
// Bouncing disc table assertion macros
// Wraps the concurrent assertions used by the disc table update logic so
// that they can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef BOUNCING_DISC_TABLE_UPDATE_UNIT_ASSERT_SVH
`define BOUNCING_DISC_TABLE_UPDATE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDT_ASSERT(lbl, prop, msg)
`define BDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/bdt_pkg.sv
// ----------------------------------------------------------------------------
// Bouncing disc table package
// Shared widths, codes, record types and arithmetic helpers.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam int unsigned MaxDiscs = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned FracW    = 4;
  localparam int unsigned PosW     = CoordW + 2 + FracW;
  localparam int unsigned ExtW     = PosW + 2;
  localparam int unsigned VelW     = 10;
  localparam int unsigned RadW     = 10;
  localparam int unsigned OutW     = 17;

  localparam logic [CoordW-1:0] WidthRst  = 12'd800;
  localparam logic [CoordW-1:0] HeightRst = 12'd600;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_CLEARED = 2'd2,
    STAT_REPORT  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic signed [ExtW-1:0] ext_t;
  typedef logic signed [VelW-1:0] vel_t;
  typedef logic        [RadW-1:0] rad_t;
  typedef logic        [IdxW-1:0] idx_t;
  typedef logic signed [OutW-1:0] out_pos_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
  } disc_pos_t;

  typedef struct packed {
    vel_t vx;
    vel_t vy;
    rad_t rad;
  } disc_mot_t;

  typedef struct packed {
    logic valid;
    logic last;
    idx_t idx;
  } tag_t;

  localparam ext_t OutMax = ExtW'(2 ** (OutW - 1) - 1);
  localparam ext_t OutMin = ExtW'(-(2 ** (OutW - 1)));

  // Negation where the most negative velocity saturates to the most positive.
  function automatic vel_t neg_sat(input vel_t v);
    logic signed [VelW:0] n;
    n = -$signed({v[VelW-1], v});
    if (n[VelW] != n[VelW-1]) begin
      return {1'b0, {(VelW - 1){1'b1}}};
    end
    return n[VelW-1:0];
  endfunction

  function automatic out_pos_t sat_out(input ext_t p);
    if (p > OutMax) begin
      return OutMax[OutW-1:0];
    end
    if (p < OutMin) begin
      return OutMin[OutW-1:0];
    end
    return p[OutW-1:0];
  endfunction

  function automatic ext_t rad_ext(input rad_t r);
    return $signed({{(ExtW - RadW){1'b0}}, r});
  endfunction

endpackage

>>> design/bdt_disc_store.sv
// ----------------------------------------------------------------------------
// Disc store
// Position and motion memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bdt_disc_store (
  input  logic               clk_i,
  input  logic               we_i,
  input  bdt_pkg::idx_t      waddr_i,
  input  bdt_pkg::disc_pos_t wpos_i,
  input  bdt_pkg::disc_mot_t wmot_i,
  input  bdt_pkg::idx_t      raddr_i,
  output bdt_pkg::disc_pos_t rpos_o,
  output bdt_pkg::disc_mot_t rmot_o
);
  import bdt_pkg::*;

  disc_pos_t pos_mem [MaxDiscs];
  disc_mot_t mot_mem [MaxDiscs];
  disc_pos_t rpos_q;
  disc_mot_t rmot_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pos_mem[waddr_i] <= wpos_i;
      mot_mem[waddr_i] <= wmot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rpos_q <= pos_mem[raddr_i];
    rmot_q <= mot_mem[raddr_i];
  end

  assign rpos_o = rpos_q;
  assign rmot_o = rmot_q;

endmodule

>>> design/bdt_motion_pipe.sv
// ----------------------------------------------------------------------------
// Disc motion pipeline
// Moves one disc by its velocity, then applies the right and top wall clamps
// in one stage and the left and bottom wall clamps at the output.
// ----------------------------------------------------------------------------
module bdt_motion_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  bdt_pkg::tag_t      tag_i,
  input  bdt_pkg::disc_pos_t pos_i,
  input  bdt_pkg::disc_mot_t mot_i,
  input  bdt_pkg::ext_t      wfx_i,
  input  bdt_pkg::ext_t      hfx_i,
  output bdt_pkg::tag_t      tag_o,
  output bdt_pkg::disc_pos_t pos_o,
  output bdt_pkg::disc_mot_t mot_o
);
  import bdt_pkg::*;

  tag_t      b_tag_q, c_tag_q;
  ext_t      b_x_q, b_y_q, c_x_q, c_y_q;
  disc_mot_t b_mot_q, c_mot_q;

  ext_t      b_x_d, b_y_d, c_x_d, c_y_d;
  disc_mot_t c_mot_d;
  ext_t      b_r, c_r;
  ext_t      o_x, o_y;

  always_comb begin
    b_x_d = ExtW'(pos_i.x) + ExtW'(mot_i.vx);
    b_y_d = ExtW'(pos_i.y) + ExtW'(mot_i.vy);
  end

  always_comb begin
    b_r     = rad_ext(b_mot_q.rad);
    c_x_d   = b_x_q;
    c_y_d   = b_y_q;
    c_mot_d = b_mot_q;
    if (b_x_q + b_r > wfx_i) begin
      c_x_d      = wfx_i - b_r;
      c_mot_d.vx = neg_sat(b_mot_q.vx);
    end
    if (b_y_q + b_r > hfx_i) begin
      c_y_d      = hfx_i - b_r;
      c_mot_d.vy = neg_sat(b_mot_q.vy);
    end
  end

  always_comb begin
    c_r   = rad_ext(c_mot_q.rad);
    o_x   = c_x_q;
    o_y   = c_y_q;
    mot_o = c_mot_q;
    if (c_x_q < c_r) begin
      o_x      = c_r;
      mot_o.vx = neg_sat(c_mot_q.vx);
    end
    if (c_y_q < c_r) begin
      o_y      = c_r;
      mot_o.vy = neg_sat(c_mot_q.vy);
    end
    pos_o.x = o_x[PosW-1:0];
    pos_o.y = o_y[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_tag_q <= '0;
      c_tag_q <= '0;
    end else if (adv_i) begin
      b_tag_q <= tag_i;
      c_tag_q <= b_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_x_q   <= b_x_d;
      b_y_q   <= b_y_d;
      b_mot_q <= mot_i;
      c_x_q   <= c_x_d;
      c_y_q   <= c_y_d;
      c_mot_q <= c_mot_d;
    end
  end

  assign tag_o = c_tag_q;

endmodule

>>> design/bouncing_disc_table_update_unit.sv
// ----------------------------------------------------------------------------
// Bouncing disc table update unit
// Stores up to 64 discs in on-chip memory, adds and clears them, and on each
// tick moves every disc, bounces it off the window walls and reports it.
// ----------------------------------------------------------------------------
// Add and clear requests give their result in the cycle after they are taken; no-op requests give none.
// A tick over N stored discs reads each disc in turn, moves it and reports it,
// one report per cycle while out_stall_i is low; the next request waits for the last disc.
// The tick rate is set by the single read port of the disc memories.
// Reset empties the table and sets the window to 800 by 600 pixels; the disc
// memories are not cleared, since only entries below the disc count are read.
`include "bouncing_disc_table_update_unit_assert.svh"

module bouncing_disc_table_update_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] click_x_i,
  input  logic [11:0] click_y_i,
  input  logic [9:0]  new_radius_i,
  input  logic signed [9:0] new_speed_x_i,
  input  logic signed [9:0] new_speed_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  disc_index_o,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic        last_o
);
  import bdt_pkg::*;

  localparam int unsigned StW = 1;
  localparam logic [StW-1:0] S_IDLE = 1'b0;
  localparam logic [StW-1:0] S_TICK = 1'b1;

  logic [StW-1:0]    state_q, state_d;
  logic [CoordW-1:0] width_q, height_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   tick_cnt_q, tick_cnt_d;
  logic [CntW-1:0]   tick_n_q, tick_n_d;
  tag_t              s1_tag_q, s1_tag_d;

  logic      out_valid_q, out_valid_d;
  status_e   status_q, status_d;
  idx_t      idx_q, idx_d;
  out_pos_t  x_q, x_d, y_q, y_d;
  logic      last_q, last_d;

  logic      adv, in_accept, issue, add_ok, wb_we;
  ext_t      wfx, hfx;
  idx_t      raddr;
  disc_pos_t rd_pos, wb_pos, new_pos;
  disc_mot_t rd_mot, wb_mot, new_mot;
  tag_t      wb_tag;
  logic      wr_we;
  idx_t      wr_addr;
  disc_pos_t wr_pos;
  disc_mot_t wr_mot;
  logic signed [CoordW+1:0] flip_y;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign issue      = (state_q == S_TICK) && adv && (tick_cnt_q < tick_n_q);
  assign add_ok     = in_accept && (opcode_e'(opcode_i) == OP_ADD)
                      && (count_q < CntW'(MaxDiscs));
  assign wb_we      = wb_tag.valid && adv;

  assign wfx = $signed({{(ExtW - CoordW - FracW){1'b0}}, width_q, {FracW{1'b0}}});
  assign hfx = $signed({{(ExtW - CoordW - FracW){1'b0}}, height_q, {FracW{1'b0}}});

  assign raddr = adv ? tick_cnt_q[IdxW-1:0] : s1_tag_q.idx;

  always_comb begin
    flip_y      = $signed({2'b00, height_q}) - (CoordW + 2)'(1)
                  - $signed({2'b00, click_y_i});
    new_pos.x   = $signed({2'b00, click_x_i, {FracW{1'b0}}});
    new_pos.y   = {flip_y, {FracW{1'b0}}};
    new_mot.vx  = new_speed_x_i;
    new_mot.vy  = new_speed_y_i;
    new_mot.rad = new_radius_i;
  end

  always_comb begin
    wr_we   = add_ok || wb_we;
    wr_addr = wb_we ? wb_tag.idx : count_q[IdxW-1:0];
    wr_pos  = wb_we ? wb_pos : new_pos;
    wr_mot  = wb_we ? wb_mot : new_mot;
  end

  bdt_disc_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_we),
    .waddr_i (wr_addr),
    .wpos_i  (wr_pos),
    .wmot_i  (wr_mot),
    .raddr_i (raddr),
    .rpos_o  (rd_pos),
    .rmot_o  (rd_mot)
  );

  bdt_motion_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tag_i  (s1_tag_q),
    .pos_i  (rd_pos),
    .mot_i  (rd_mot),
    .wfx_i  (wfx),
    .hfx_i  (hfx),
    .tag_o  (wb_tag),
    .pos_o  (wb_pos),
    .mot_o  (wb_mot)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    tick_cnt_d  = tick_cnt_q;
    tick_n_d    = tick_n_q;
    s1_tag_d    = s1_tag_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    idx_d       = idx_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;

    if (adv) begin
      out_valid_d = 1'b0;
      s1_tag_d.valid = issue;
      s1_tag_d.idx   = tick_cnt_q[IdxW-1:0];
      s1_tag_d.last  = (tick_cnt_q + CntW'(1)) == tick_n_q;
    end
    if (issue) begin
      tick_cnt_d = tick_cnt_q + CntW'(1);
    end

    if (wb_we) begin
      out_valid_d = 1'b1;
      status_d    = STAT_REPORT;
      idx_d       = wb_tag.idx;
      x_d         = sat_out(ExtW'(wb_pos.x));
      y_d         = sat_out(ExtW'(wb_pos.y));
      last_d      = wb_tag.last;
      if (wb_tag.last) begin
        state_d = S_IDLE;
      end
    end

    if (in_accept) begin
      case (opcode_e'(opcode_i))
        OP_ADD: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          if (add_ok) begin
            status_d = STAT_ADDED;
            idx_d    = count_q[IdxW-1:0];
            x_d      = sat_out(ExtW'(new_pos.x));
            y_d      = sat_out(ExtW'(new_pos.y));
            count_d  = count_q + CntW'(1);
          end else begin
            status_d = STAT_FULL;
            idx_d    = '0;
            x_d      = '0;
            y_d      = '0;
          end
        end
        OP_CLEAR: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          status_d    = STAT_CLEARED;
          idx_d       = '0;
          x_d         = '0;
          y_d         = '0;
          count_d     = '0;
        end
        OP_TICK: begin
          if (count_q != '0) begin
            state_d    = S_TICK;
            tick_cnt_d = '0;
            tick_n_d   = count_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
      count_q     <= '0;
      tick_cnt_q  <= '0;
      tick_n_q    <= '0;
      s1_tag_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      tick_cnt_q  <= tick_cnt_d;
      tick_n_q    <= tick_n_d;
      s1_tag_q    <= s1_tag_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    idx_q    <= idx_d;
    x_q      <= x_d;
    y_q      <= y_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign disc_index_o = idx_q;
  assign pos_x_o      = x_q;
  assign pos_y_o      = y_q;
  assign last_o       = last_q;

  `BDT_ASSERT(a_count_max, count_q <= CntW'(MaxDiscs), "disc count above table size")
  `BDT_ASSERT(a_issue_bound, tick_cnt_q <= tick_n_q, "tick issued past the disc count")
  `BDT_ASSERT(a_wb_no_overlap, (wr_we && s1_tag_q.valid) |-> (wr_addr != s1_tag_q.idx), "write hits entry in flight")
  `BDT_ASSERT_NEXT(a_tick_holds_input, in_accept && (opcode_i == OP_TICK) && (count_q != '0), in_stall_o, "request taken during tick")

endmodule

>>> tb/disc_bounce_checker.sv
// ----------------------------------------------------------------------------
// Disc bounce checker
// Watches the configuration port, the request channel and the result channel of the disc
// table, keeps its own copy of the window and of every stored disc, works
// out the results that each accepted request must produce, and compares
// every accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module disc_bounce_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         opcode_i,
  input  logic [11:0]        click_x_i,
  input  logic [11:0]        click_y_i,
  input  logic [9:0]         new_radius_i,
  input  logic signed [9:0]  new_speed_x_i,
  input  logic signed [9:0]  new_speed_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [5:0]         disc_index_i,
  input  logic signed [16:0] pos_x_i,
  input  logic signed [16:0] pos_y_i,
  input  logic               last_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdt_pkg::*;

  typedef struct packed {
    status_e  status;
    idx_t     idx;
    out_pos_t x;
    out_pos_t y;
    logic     last;
  } report_t;

  report_t     pending_reports[$];
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned disc_count;
  int unsigned error_count;
  int          disc_x[MaxDiscs];
  int          disc_y[MaxDiscs];
  int          disc_vx[MaxDiscs];
  int          disc_vy[MaxDiscs];
  int          disc_r[MaxDiscs];

  function automatic out_pos_t clip17(input int v);
    if (v > 65535) begin
      return out_pos_t'(65535);
    end
    if (v < -65536) begin
      return out_pos_t'(-65536);
    end
    return out_pos_t'(v);
  endfunction

  function automatic int reverse_speed(input int v);
    return (-v > 511) ? 511 : -v;
  endfunction

  function automatic report_t make_report(input status_e status, input int unsigned idx,
                                          input int x, input int y, input logic last);
    report_t rep;
    rep.status = status;
    rep.idx    = idx_t'(idx);
    rep.x      = clip17(x);
    rep.y      = clip17(y);
    rep.last   = last;
    return rep;
  endfunction

  function automatic void predict_request(input opcode_e op, input logic [11:0] cx,
                                          input logic [11:0] cy, input logic [9:0] r,
                                          input logic signed [9:0] sx,
                                          input logic signed [9:0] sy);
    int unsigned k;
    int          wall_x;
    int          wall_y;
    wall_x = int'(frame_w) * 16;
    wall_y = int'(frame_h) * 16;
    case (op)
      OP_ADD: begin
        if (disc_count >= MaxDiscs) begin
          pending_reports.push_back(make_report(STAT_FULL, 0, 0, 0, 1'b1));
        end else begin
          k = disc_count;
          disc_x[k]  = int'(cx) * 16;
          disc_y[k]  = (int'(frame_h) - 1 - int'(cy)) * 16;
          disc_r[k]  = int'(r);
          disc_vx[k] = int'(sx);
          disc_vy[k] = int'(sy);
          disc_count = k + 1;
          pending_reports.push_back(make_report(STAT_ADDED, k, disc_x[k], disc_y[k], 1'b1));
        end
      end
      OP_CLEAR: begin
        disc_count = 0;
        pending_reports.push_back(make_report(STAT_CLEARED, 0, 0, 0, 1'b1));
      end
      OP_TICK: begin
        for (k = 0; k < disc_count; k++) begin
          disc_x[k] += disc_vx[k];
          disc_y[k] += disc_vy[k];
          if (disc_x[k] + disc_r[k] > wall_x) begin
            disc_x[k]  = wall_x - disc_r[k];
            disc_vx[k] = reverse_speed(disc_vx[k]);
          end
          if (disc_x[k] - disc_r[k] < 0) begin
            disc_x[k]  = disc_r[k];
            disc_vx[k] = reverse_speed(disc_vx[k]);
          end
          if (disc_y[k] + disc_r[k] > wall_y) begin
            disc_y[k]  = wall_y - disc_r[k];
            disc_vy[k] = reverse_speed(disc_vy[k]);
          end
          if (disc_y[k] - disc_r[k] < 0) begin
            disc_y[k]  = disc_r[k];
            disc_vy[k] = reverse_speed(disc_vy[k]);
          end
          pending_reports.push_back(make_report(STAT_REPORT, k, disc_x[k], disc_y[k],
                                                k + 1 == disc_count));
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      frame_w     = WidthRst;
      frame_h     = HeightRst;
      disc_count  = 0;
      error_count = 0;
      pending_reports.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WIDTH) begin
          frame_w = cfg_data_i;
        end else begin
          frame_h = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(opcode_e'(opcode_i), click_x_i, click_y_i, new_radius_i,
                        new_speed_x_i, new_speed_y_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: unexpected result status %0d idx %0d x %0d y %0d last %0b",
                     $time, status_i, disc_index_i, pos_x_i, pos_y_i, last_i);
          end
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          if (status_i !== want.status || disc_index_i !== want.idx ||
              pos_x_i !== want.x || pos_y_i !== want.y || last_i !== want.last) begin
            if (error_count < 10) begin
              $display("%0t: expected status %0d idx %0d x %0d y %0d last %0b", $time,
                       want.status, want.idx, want.x, want.y, want.last);
              $display("%0t: got      status %0d idx %0d x %0d y %0d last %0b", $time,
                       status_i, disc_index_i, pos_x_i, pos_y_i, last_i);
            end
            error_count++;
          end
        end
      end
      pending_o <= pending_reports.size();
      errors_o  <= error_count;
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Disc table update unit testbench
// Drives add, clear, tick and no-op requests into the disc table under
// several window sizes and three patterns of sender and receiver idling,
// and leaves all prediction and comparison to the disc bounce checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bdt_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 16;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [11:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         opcode_i;
  logic [11:0]        click_x_i;
  logic [11:0]        click_y_i;
  logic [9:0]         new_radius_i;
  logic signed [9:0]  new_speed_x_i;
  logic signed [9:0]  new_speed_y_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [5:0]         disc_index_o;
  logic signed [16:0] pos_x_o;
  logic signed [16:0] pos_y_o;
  logic               last_o;

  int unsigned pending_count;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned win_w;
  int unsigned win_h;

  bouncing_disc_table_update_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .click_x_i    (click_x_i),
    .click_y_i    (click_y_i),
    .new_radius_i (new_radius_i),
    .new_speed_x_i(new_speed_x_i),
    .new_speed_y_i(new_speed_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .disc_index_o (disc_index_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .last_o       (last_o)
  );

  disc_bounce_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .opcode_i     (opcode_i),
    .click_x_i    (click_x_i),
    .click_y_i    (click_y_i),
    .new_radius_i (new_radius_i),
    .new_speed_x_i(new_speed_x_i),
    .new_speed_y_i(new_speed_y_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .disc_index_i (disc_index_o),
    .pos_x_i      (pos_x_o),
    .pos_y_i      (pos_y_o),
    .last_i       (last_o),
    .pending_o    (pending_count),
    .errors_o     (mismatch_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_request(input opcode_e op, input logic [11:0] cx, input logic [11:0] cy,
                              input logic [9:0] r, input logic [9:0] sx, input logic [9:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    click_x_i     <= cx;
    click_y_i     <= cy;
    new_radius_i  <= r;
    new_speed_x_i <= sx;
    new_speed_y_i <= sy;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic push_op(input opcode_e op);
    push_request(op, 12'($urandom), 12'($urandom), 10'($urandom), 10'($urandom),
                 10'($urandom));
  endtask

  task automatic random_add();
    logic [11:0] cx;
    logic [11:0] cy;
    logic [9:0]  r;
    if ($urandom_range(3) == 0) begin
      cx = 12'($urandom);
      cy = 12'($urandom);
    end else begin
      cx = 12'($urandom_range(win_w - 1));
      cy = 12'($urandom_range(win_h - 1));
    end
    r = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(48));
    push_request(OP_ADD, cx, cy, r, 10'($urandom), 10'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [11:0] w, input logic [11:0] h);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_w = w;
    win_h = h;
  endtask

  task automatic random_phase(input bit fill_table);
    int unsigned issued;
    int unsigned burst;
    opcode_e     op;
    issued = 0;
    if (fill_table) begin
      push_op(OP_CLEAR);
      repeat (MaxDiscs + 2) random_add();
      push_op(OP_TICK);
      issued = MaxDiscs + 4;
    end
    while (issued < (fill_table ? 70 : 6)) begin
      if ($urandom_range(3) == 0) begin
        push_op(OP_CLEAR);
        issued++;
      end
      burst = $urandom_range(1, 6);
      repeat (burst) random_add();
      issued += burst;
      burst = $urandom_range(1, 4);
      repeat (burst) push_op(OP_TICK);
      issued += burst;
      if ($urandom_range(4) == 0) begin
        op = opcode_e'($urandom_range(3));
        if (op == OP_ADD) begin
          random_add();
        end else begin
          push_op(op);
        end
        if (op != OP_NOP) begin
          issued++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_NOP;
    click_x_i     = '0;
    click_y_i     = '0;
    new_radius_i  = '0;
    new_speed_x_i = '0;
    new_speed_y_i = '0;
    send_idle_pct = 28;
    recv_idle_pct = 73;
    win_w         = WidthRst;
    win_h         = HeightRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_op(OP_TICK);
    push_request(OP_NOP, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF, 10'h3FF);
    push_op(OP_CLEAR);
    push_request(OP_ADD, 12'd0, 12'd599, 10'd0, -10'sd512, -10'sd512);
    push_request(OP_ADD, 12'hFFF, 12'd0, 10'h3FF, 10'sd511, 10'sd511);
    push_request(OP_ADD, 12'd400, 12'hFFF, 10'h3FF, 10'sd0, 10'sd0);
    push_request(OP_ADD, 12'd799, 12'd300, 10'd16, 10'sd100, -10'sd100);
    repeat (3) push_op(OP_TICK);
    push_op(OP_NOP);
    push_op(OP_CLEAR);
    push_op(OP_TICK);

    set_window(12'd1, 12'd1);
    push_request(OP_ADD, 12'd0, 12'd0, 10'd100, 10'sd5, -10'sd5);
    push_request(OP_ADD, 12'hFFF, 12'hFFF, 10'd0, -10'sd1, 10'sd1);
    repeat (2) push_op(OP_TICK);
    push_op(OP_CLEAR);

    set_window(12'hFFF, 12'hFFF);
    push_request(OP_ADD, 12'hFFF, 12'd0, 10'd0, 10'sd511, 10'sd511);
    push_request(OP_ADD, 12'd0, 12'hFFF, 10'h3FF, -10'sd512, -10'sd512);
    push_op(OP_TICK);
    push_op(OP_CLEAR);

    set_window(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
    random_phase(1'b0);

    send_idle_pct = 73;
    recv_idle_pct = 28;
    set_window(12'($urandom_range(1, 200)), 12'($urandom_range(1, 200)));
    random_phase(1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
    random_phase(1'b0);
    settle();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
